// ===== rtl/core/ecc_pkg.sv =====
// Shared types, constants and calendar helpers for the epoch/calendar converter.
// No dependencies; imported by ecc_ctrl, ecc_datapath and epoch_calendar_converter_unit.
package ecc_pkg;

    // Default last supported calendar year
    localparam int unsigned ECC_LAST_YEAR = 9999;

    localparam int unsigned ECC_FIRST_YEAR = 1970;

    // Seconds per calendar unit
    localparam logic [21:0] ECC_DAY_SECS       = 22'd86400;
    localparam logic [21:0] ECC_HOUR_SECS      = 22'd3600;
    localparam logic [21:0] ECC_MIN_SECS       = 22'd60;
    localparam logic [24:0] ECC_YEAR_SECS      = 25'd31536000;
    localparam logic [24:0] ECC_LEAP_YEAR_SECS = 25'd31622400;

    // Year 1970 taken modulo 100 and modulo 400
    localparam logic [6:0] ECC_Y0_MOD100 = 7'd70;
    localparam logic [8:0] ECC_Y0_MOD400 = 9'd370;

    localparam logic [3:0] ECC_LAST_MONTH = 4'd12;

    // Input request: calendar fields or epoch seconds, direction chosen by mode
    typedef struct packed {
        logic        mode;
        logic [37:0] epoch_in;
        logic [13:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
    } ecc_req_t;

    // Result: epoch or calendar fields plus range flag
    typedef struct packed {
        logic [37:0] epoch_out;
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic        range_error;
    } ecc_rsp_t;

    // Direction codes
    localparam logic ECC_MODE_TO_EPOCH = 1'b0;
    localparam logic ECC_MODE_TO_CAL   = 1'b1;

    // Datapath operations
    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_YEAR,
        DP_MONTH,
        DP_DAY,
        DP_HOUR,
        DP_MIN,
        DP_SUM
    } ecc_op_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEARS,
        ST_MONTHS,
        ST_SUM,
        ST_DAYS,
        ST_HOURS,
        ST_MINS,
        ST_DONE
    } ecc_state_t;

    // Controller to datapath
    typedef struct packed {
        ecc_op_t op;
        logic    out_load;
    } ecc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic err;
        logic mode;
        logic year_more;
        logic month_more;
        logic day_more;
        logic hour_more;
        logic min_more;
    } ecc_status_t;

    // Days from 1970-01-01 to January 1 of year y (elaboration use only)
    function automatic longint unsigned ecc_days_to_year(input int unsigned y);
        longint unsigned n;
        longint unsigned leaps;
        n     = longint'(y) - 1;
        leaps = n / 4 - n / 100 + n / 400 - 477;
        return 365 * (longint'(y) - 1970) + leaps;
    endfunction

    // Seconds in month m, leap selects the long February
    function automatic logic [21:0] ecc_month_secs(input logic [3:0] m, input logic leap);
        logic [21:0] secs;
        unique case (m)
            4'd4, 4'd6, 4'd9, 4'd11: secs = 22'd2592000;
            4'd2:                    secs = leap ? 22'd2505600 : 22'd2419200;
            default:                 secs = 22'd2678400;
        endcase
        return secs;
    endfunction

endpackage

// ===== rtl/core/ecc_ctrl.sv =====
// Sequencing state machine for the epoch/calendar converter.
// Depends on ecc_pkg; drives the ecc_datapath through ecc_cmd_t.
module ecc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                out_free,
    input  ecc_pkg::ecc_status_t status,
    output ecc_pkg::ecc_cmd_t    cmd
);
    import ecc_pkg::*;

    ecc_state_t state_reg;
    ecc_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_YEARS;
            end
            ST_YEARS: begin
                if (status.err)             state_next = ST_DONE;
                else if (!status.year_more) state_next = ST_MONTHS;
            end
            ST_MONTHS: begin
                if (!status.month_more) begin
                    state_next = (status.mode == ECC_MODE_TO_CAL) ? ST_DAYS : ST_SUM;
                end
            end
            ST_SUM:   state_next = ST_DONE;
            ST_DAYS: begin
                if (!status.day_more) state_next = ST_HOURS;
            end
            ST_HOURS: begin
                if (!status.hour_more) state_next = ST_MINS;
            end
            ST_MINS: begin
                if (!status.min_more) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd.op       = DP_NOP;
        cmd.out_load = 1'b0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = DP_LOAD;
            end
            ST_YEARS: begin
                if (!status.err && status.year_more) cmd.op = DP_YEAR;
            end
            ST_MONTHS: begin
                if (status.month_more) cmd.op = DP_MONTH;
            end
            ST_SUM:   cmd.op = DP_SUM;
            ST_DAYS: begin
                if (status.day_more) cmd.op = DP_DAY;
            end
            ST_HOURS: begin
                if (status.hour_more) cmd.op = DP_HOUR;
            end
            ST_MINS: begin
                if (status.min_more) cmd.op = DP_MIN;
            end
            ST_DONE:  cmd.out_load = out_free;
            default:  cmd.op = DP_NOP;
        endcase
    end

endmodule

// ===== rtl/core/ecc_datapath.sv =====
// Datapath for the epoch/calendar converter: one 38-bit add/subtract accumulator,
// year and month walkers with leap tracking, and the time-of-day split. Uses ecc_pkg.
module ecc_datapath #(
    parameter int unsigned LAST_YEAR = ecc_pkg::ECC_LAST_YEAR
) (
    input  logic                 aclk,
    input  ecc_pkg::ecc_req_t    s_req,
    input  ecc_pkg::ecc_cmd_t    cmd,
    output ecc_pkg::ecc_status_t status,
    output ecc_pkg::ecc_rsp_t    result
);
    import ecc_pkg::*;

    // First second past the supported range
    localparam logic [37:0] EPOCH_LIMIT =
        38'(ecc_days_to_year(LAST_YEAR + 1) * longint'(ECC_DAY_SECS));
    localparam logic [13:0] LAST_YEAR_W = 14'(LAST_YEAR);
    localparam logic [13:0] FIRST_YEAR_W = 14'(ECC_FIRST_YEAR);

    logic        mode_reg;
    logic        err_reg;
    logic [13:0] year_lim_reg;
    logic [3:0]  month_lim_reg;
    logic [21:0] tod_reg;
    logic [37:0] acc_reg;
    logic [13:0] y_reg;
    logic [6:0]  c100_reg;
    logic [8:0]  c400_reg;
    logic [3:0]  m_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  min_reg;

    logic        leap;
    logic [24:0] ysecs;
    logic [21:0] msecs;
    logic        cal_bad;
    logic [4:0]  day_m1;
    logic [21:0] tod_calc;
    logic [37:0] step;
    logic [37:0] acc_step;

    // Leap rule from the year's low bits and running century counters
    assign leap  = ((y_reg[1:0] == 2'b00) && (c100_reg != 7'd0)) || (c400_reg == 9'd0);
    assign ysecs = leap ? ECC_LEAP_YEAR_SECS : ECC_YEAR_SECS;
    assign msecs = ecc_month_secs(m_reg, leap);

    // Field checks for calendar-to-epoch requests
    assign cal_bad = (s_req.year_in < FIRST_YEAR_W) || (s_req.year_in > LAST_YEAR_W) ||
                     (s_req.month_in == 4'd0) || (s_req.month_in > ECC_LAST_MONTH) ||
                     (s_req.day_in == 5'd0) || (s_req.hour_in > 5'd23) ||
                     (s_req.minute_in > 6'd59) || (s_req.second_in > 6'd59);

    // Seconds within the month, from the request fields
    assign day_m1   = s_req.day_in - 5'd1;
    assign tod_calc = 22'(day_m1) * ECC_DAY_SECS + 22'(s_req.hour_in) * ECC_HOUR_SECS +
                      22'(s_req.minute_in) * ECC_MIN_SECS + 22'(s_req.second_in);

    // Step size for the shared accumulator
    always_comb begin
        unique case (cmd.op)
            DP_YEAR:  step = 38'(ysecs);
            DP_MONTH: step = 38'(msecs);
            DP_DAY:   step = 38'(ECC_DAY_SECS);
            DP_HOUR:  step = 38'(ECC_HOUR_SECS);
            DP_MIN:   step = 38'(ECC_MIN_SECS);
            DP_SUM:   step = 38'(tod_reg);
            default:  step = 38'd0;
        endcase
    end

    // Calendar-to-epoch adds, epoch-to-calendar subtracts
    assign acc_step = (mode_reg == ECC_MODE_TO_CAL) ? (acc_reg - step) : (acc_reg + step);

    // Walk status
    always_comb begin
        status.err        = err_reg;
        status.mode       = mode_reg;
        status.year_more  = (mode_reg == ECC_MODE_TO_CAL) ?
                            ((y_reg < LAST_YEAR_W) && (acc_reg >= 38'(ysecs))) :
                            (y_reg < year_lim_reg);
        status.month_more = (mode_reg == ECC_MODE_TO_CAL) ?
                            ((m_reg < ECC_LAST_MONTH) && (acc_reg >= 38'(msecs))) :
                            (m_reg < month_lim_reg);
        status.day_more   = acc_reg >= 38'(ECC_DAY_SECS);
        status.hour_more  = acc_reg >= 38'(ECC_HOUR_SECS);
        status.min_more   = acc_reg >= 38'(ECC_MIN_SECS);
    end

    // Working registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            DP_LOAD: begin
                mode_reg      <= s_req.mode;
                err_reg       <= (s_req.mode == ECC_MODE_TO_CAL) ?
                                 (s_req.epoch_in >= EPOCH_LIMIT) : cal_bad;
                year_lim_reg  <= s_req.year_in;
                month_lim_reg <= s_req.month_in;
                tod_reg       <= tod_calc;
                acc_reg       <= (s_req.mode == ECC_MODE_TO_CAL) ? s_req.epoch_in : 38'd0;
                y_reg         <= FIRST_YEAR_W;
                c100_reg      <= ECC_Y0_MOD100;
                c400_reg      <= ECC_Y0_MOD400;
                m_reg         <= 4'd1;
                day_reg       <= 5'd0;
                hour_reg      <= 5'd0;
                min_reg       <= 6'd0;
            end
            DP_YEAR: begin
                acc_reg  <= acc_step;
                y_reg    <= y_reg + 14'd1;
                c100_reg <= (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                c400_reg <= (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
            end
            DP_MONTH: begin
                acc_reg <= acc_step;
                m_reg   <= m_reg + 4'd1;
            end
            DP_DAY: begin
                acc_reg <= acc_step;
                day_reg <= day_reg + 5'd1;
            end
            DP_HOUR: begin
                acc_reg  <= acc_step;
                hour_reg <= hour_reg + 5'd1;
            end
            DP_MIN: begin
                acc_reg <= acc_step;
                min_reg <= min_reg + 6'd1;
            end
            DP_SUM: begin
                acc_reg <= acc_step;
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // Result assembly
    always_comb begin
        result = '0;
        if (err_reg) begin
            result.range_error = 1'b1;
        end else if (mode_reg == ECC_MODE_TO_CAL) begin
            result.year_out   = y_reg;
            result.month_out  = m_reg;
            result.day_out    = day_reg + 5'd1;
            result.hour_out   = hour_reg;
            result.minute_out = min_reg;
            result.second_out = acc_reg[5:0];
        end else begin
            result.epoch_out = acc_reg;
        end
    end

endmodule

// ===== rtl/core/epoch_calendar_converter_unit.sv =====
// Top level of the epoch/calendar converter: controller, datapath and result register.
// Depends on ecc_pkg, ecc_ctrl and ecc_datapath.
//
//   Channel   Ports                       Direction  Payload
//   request   s_valid, s_ready, s_req     in         ecc_req_t
//   result    m_valid, m_ready, m_rsp     out        ecc_rsp_t
//
// One request at a time; each calendar unit walked is one step of the shared
// 38-bit add/subtract accumulator. Calendar to epoch walks the years from 1970
// and the months, then adds the time within the month. Epoch to calendar walks
// years, months, days, hours and minutes. A finished result sits in the output
// register, so the next request is taken while it waits for m_ready.
// Synchronous active-low reset clears the controller and the result valid flag.
module epoch_calendar_converter_unit #(
    parameter int unsigned LAST_YEAR = ecc_pkg::ECC_LAST_YEAR
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ecc_pkg::ecc_req_t s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output ecc_pkg::ecc_rsp_t m_rsp
);
    import ecc_pkg::*;

    ecc_cmd_t    cmd;
    ecc_status_t status;
    ecc_rsp_t    result;
    logic        out_free;
    logic        m_valid_reg;
    ecc_rsp_t    m_rsp_reg;

    // Output slot free when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    ecc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    ecc_datapath #(
        .LAST_YEAR (LAST_YEAR)
    ) u_datapath (
        .aclk   (aclk),
        .s_req  (s_req),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_rsp_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule
